@@ hw/rtl/bgrhsv_pkg.sv @@
// Package for the BGR to HSV pixel core: pipeline stage payload type and
// fixed conversion constants. No dependencies.
package bgrhsv_pkg;

  // One quotient bit per divider stage; both quotients fit in 8 bits.
  localparam int DIV_STEPS = 8;

  // Hue offsets on the half-degree scale for each maximum channel.
  localparam logic [7:0] HUE_BASE_BLUE     = 8'd120;
  localparam logic [7:0] HUE_BASE_GREEN    = 8'd60;
  localparam logic [7:0] HUE_BASE_RED      = 8'd0;
  localparam logic [7:0] HUE_BASE_RED_WRAP = 8'd180;
  localparam logic [7:0] HUE_MAX           = 8'd179;

  typedef struct packed {
    logic [7:0]  v;          // channel maximum, also the saturation divisor
    logic        sat_zero;   // black pixel
    logic [15:0] sat_rem;    // partial remainder of 255*diff / v
    logic [7:0]  sat_q;
    logic        hue_zero;   // gray pixel
    logic [15:0] hue_rem;    // partial remainder of 30*|x| / diff
    logic [7:0]  hue_div;    // diff
    logic [7:0]  hue_q;
    logic        hue_neg;    // angle offset x is negative
    logic [7:0]  hue_base;
  } hsv_stage_t;

endpackage

@@ hw/rtl/bgr_to_hsv_pixel_core.sv @@
// BGR to HSV pixel core: pipelined max/min front end, two one-bit-per-stage
// restoring dividers and a hue correction stage. Depends on bgrhsv_pkg.
//
// Usage:
//   Input channel (pix_valid / pix_stall) carries one pixel per transaction
//   as blue, green, red bytes. Output channel (hsv_valid / hsv_stall) carries
//   hue (0..179, half degrees), saturation and brightness for each pixel, in
//   order, one result per input.
//   Stage 0 finds max, min, chroma and the hue offset; stages 1..8 each
//   resolve one quotient bit of both divisions; the output register
//   applies the hue rounding and channel offset.
//   Throughput: one pixel per clock while hsv_stall is low, set by the
//   8-stage divider pipeline that takes a new operand pair every cycle
//   unless back-pressure holds it.
//   Stall: each stage advances when the stage after it is empty or moving,
//   so bubbles collapse and the core keeps taking pixels while a result
//   waits, until every stage is full; then pix_stall rises. Nothing is lost
//   or repeated.
//   Reset (rst, synchronous): clear all valid bits; the pipeline comes up
//   empty and ready.
module bgr_to_hsv_pixel_core
  import bgrhsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic       hsv_valid,
  input  logic       hsv_stall,
  output logic [7:0] hue,
  output logic [7:0] saturation,
  output logic [7:0] brightness
);

  localparam int LAST = DIV_STEPS;

  // Stage registers: stage 0 is the front end, stages 1..LAST the divider.
  hsv_stage_t       pipe       [0:LAST];
  hsv_stage_t       front_next;
  hsv_stage_t       pipe_next  [1:LAST];
  logic [LAST:0]    valid;
  logic [LAST:0]    ready;
  logic             out_ready;

  // Front end: max, min, chroma, hue offset and divider operands.
  logic [7:0]       vmax;
  logic [7:0]       vmin;
  logic [7:0]       diff;
  logic signed [8:0] hx;
  logic [7:0]       hx_mag;
  logic [7:0]       base;

  always_comb begin
    vmax = blue;
    if (green > vmax) vmax = green;
    if (red > vmax) vmax = red;
    vmin = blue;
    if (green < vmin) vmin = green;
    if (red < vmin) vmin = red;
    diff = vmax - vmin;

    // Blue wins ties over green, green over red.
    priority if (vmax == blue) begin
      hx   = $signed({1'b0, red}) - $signed({1'b0, green});
      base = HUE_BASE_BLUE;
    end else if (vmax == green) begin
      hx   = $signed({1'b0, blue}) - $signed({1'b0, red});
      base = HUE_BASE_GREEN;
    end else begin
      hx   = $signed({1'b0, green}) - $signed({1'b0, blue});
      // Negative red angles wrap by a full turn.
      base = hx[8] ? HUE_BASE_RED_WRAP : HUE_BASE_RED;
    end
    hx_mag = hx[8] ? 8'(-hx) : hx[7:0];

    front_next.v        = vmax;
    front_next.sat_zero = (vmax == 8'd0);
    front_next.sat_rem  = {diff, 8'd0} - {8'd0, diff};               // 255*diff
    front_next.sat_q    = 8'd0;
    front_next.hue_zero = (diff == 8'd0);
    front_next.hue_rem  = {3'd0, hx_mag, 5'd0} - {7'd0, hx_mag, 1'b0}; // 30*|x|
    front_next.hue_div  = diff;
    front_next.hue_q    = 8'd0;
    front_next.hue_neg  = hx[8];
    front_next.hue_base = base;
  end

  // Divider stages: stage j resolves quotient bit DIV_STEPS-j of both
  // divisions by restoring compare and subtract.
  always_comb begin
    logic [15:0] sat_sh;
    logic [15:0] hue_sh;
    for (int j = 1; j <= LAST; j++) begin
      pipe_next[j] = pipe[j-1];
      sat_sh = {8'd0, pipe[j-1].v} << (DIV_STEPS - j);
      hue_sh = {8'd0, pipe[j-1].hue_div} << (DIV_STEPS - j);
      if (pipe[j-1].sat_rem >= sat_sh) begin
        pipe_next[j].sat_rem            = pipe[j-1].sat_rem - sat_sh;
        pipe_next[j].sat_q[DIV_STEPS-j] = 1'b1;
      end
      if (pipe[j-1].hue_rem >= hue_sh) begin
        pipe_next[j].hue_rem            = pipe[j-1].hue_rem - hue_sh;
        pipe_next[j].hue_q[DIV_STEPS-j] = 1'b1;
      end
    end
  end

  // Ready chain: a stage takes new data when it is empty or draining.
  always_comb begin
    out_ready   = !hsv_valid || !hsv_stall;
    ready[LAST] = !valid[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign pix_stall = !ready[0];

  // Output stage: floor of a negative offset rounds away from zero.
  logic       rem_nz;
  logic [7:0] hue_next;
  logic [7:0] sat_next;

  always_comb begin
    rem_nz = |pipe[LAST].hue_rem;
    if (pipe[LAST].hue_zero) begin
      hue_next = 8'd0;
    end else if (pipe[LAST].hue_neg) begin
      hue_next = pipe[LAST].hue_base - pipe[LAST].hue_q - {7'd0, rem_nz};
    end else begin
      hue_next = pipe[LAST].hue_base + pipe[LAST].hue_q;
    end
    sat_next = pipe[LAST].sat_zero ? 8'd0 : pipe[LAST].sat_q;
  end

  // Advance valid bits; hold a stage whose successor is full and stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      hsv_valid <= 1'b0;
    end else begin
      if (ready[0]) valid[0] <= pix_valid;
      for (int i = 1; i <= LAST; i++) begin
        if (ready[i]) valid[i] <= valid[i-1];
      end
      if (out_ready) hsv_valid <= valid[LAST];
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (ready[0]) pipe[0] <= front_next;
    for (int i = 1; i <= LAST; i++) begin
      if (ready[i]) pipe[i] <= pipe_next[i];
    end
    if (out_ready) begin
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= pipe[LAST].v;
    end
  end

`ifndef SYNTHESIS
  // Hue never leaves the half-degree range.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hue <= HUE_MAX))
    else $error("hue out of range");

  // A black pixel has zero saturation.
  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && (brightness == 8'd0)) |-> (saturation == 8'd0))
    else $error("nonzero saturation for black pixel");

  // An empty front stage never back-pressures the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !valid[0] |-> !pix_stall)
    else $error("input stalled with empty front stage");

  // A stalled result is held, never dropped.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv_stall) |=> (hsv_valid && $stable(hue) && $stable(saturation)))
    else $error("stalled result lost");
`endif

endmodule
